// ===== rtl/core/pidaw_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the PID controller with conditional anti-windup:
// default parameters, register indexes, reset values and sequencer types.
// Depends on nothing; used by pid_conditional_antiwindup.
package pidaw_pkg;

  // Default datapath geometry
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths on the ports
  localparam int FIELD_W   = 32;
  localparam int PERIOD_W  = 31;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_CEILING = 3'd5;

  // Register reset values, Q16.16
  localparam logic signed [FIELD_W-1:0] PROP_GAIN_RST     = 32'sd163840;
  localparam logic signed [FIELD_W-1:0] INT_GAIN_RST      = 32'sd78643;
  localparam logic signed [FIELD_W-1:0] DERIV_GAIN_RST    = 32'sd6554;
  localparam logic [PERIOD_W-1:0]       SAMPLE_PERIOD_RST = 31'd6554;
  localparam logic signed [FIELD_W-1:0] DRIVE_FLOOR_RST   = 32'sd0;
  localparam logic signed [FIELD_W-1:0] DRIVE_CEILING_RST = 32'sd6553600;

  // Item kinds carried on in_tuser
  localparam logic OP_RUN   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DIV_DONE,
    ST_MUL_SETUP,
    ST_MUL,
    ST_MUL_DONE,
    ST_SUMS,
    ST_CHECK,
    ST_CLAMP,
    ST_DONE
  } pidaw_state_t;

  // Which product the shared unit is forming
  typedef enum logic [1:0] {
    MUL_P,
    MUL_D,
    MUL_T,
    MUL_INC
  } mul_sel_t;

endpackage

// ===== rtl/core/pid_conditional_antiwindup.sv =====
`timescale 1ns / 1ps
// PID controller with conditional-integration anti-windup, signed fixed point.
// Uses pidaw_pkg for register indexes, reset values and sequencer types.
// Usage:
//   in_*  : one transaction per item. in_tuser is the opcode (0 run, 1 clear),
//           in_tdata holds target [31:0] and measurement [63:32].
//   out_* : one transaction per item. out_tdata is the clamped drive [31:0],
//           out_tuser is the windup_frozen flag.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Sequencing: one shared add/subtract unit under a small sequencer runs a restoring
//   divide of DATA_WIDTH steps, then four shift-add multiplies of
//   MW = max(32, DATA_WIDTH) steps each. The divide is skipped when the error is
//   unchanged or the quotient would overflow and saturates; a clear item skips
//   the arithmetic and goes straight to the result register. in_tready is high
//   only while the sequencer is idle, so the next item is taken in the cycle
//   after the result register loads.
// An output register holds the finished result; when the receiver stalls it
//   keeps the transaction, one more item may be accepted, and its result waits
//   in the sequencer until the register frees.
// Reset (rst_n low, synchronous) restores all register reset values and
//   zeroes the integral and the previous error.
module pid_conditional_antiwindup #(
  parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] target, [63:32] measurement
  input  logic [0:0]  in_tuser,   // [0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive
  output logic [0:0]  out_tuser,  // [0] windup_frozen
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int FW = pidaw_pkg::FIELD_W;
  localparam int PW = pidaw_pkg::PERIOD_W;
  localparam int MW = (DW > FW) ? DW : FW;          // multiplier operand width
  localparam int AW = MW + 1;                       // shared adder width
  localparam int CW = $clog2(MW + 1);
  localparam int EW = (DW + 1 > FW + 1) ? DW + 1 : FW + 1;
  localparam int SW = (DW + 2 > FW) ? DW + 2 : FW;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // Configuration registers
  logic signed [FW-1:0] kp_r, ki_r, kd_r, floor_r, ceil_r;
  logic [PW-1:0]        per_r;

  // Control state
  pidaw_pkg::pidaw_state_t state_r, state_nxt;
  pidaw_pkg::mul_sel_t     mul_sel_r, mul_sel_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r;

  // Controller state
  logic signed [DW-1:0] integ_r, integ_nxt;
  logic signed [DW-1:0] last_err_r, last_err_nxt;

  // Working registers
  logic signed [DW-1:0] err_r, err_nxt;
  logic signed [DW:0]   diff_r, diff_nxt;
  logic signed [DW-1:0] dq_r, dq_nxt;
  logic signed [DW-1:0] p_r, p_nxt, dterm_r, dterm_nxt, t_r, t_nxt, inc_r, inc_nxt;
  logic signed [DW-1:0] pi_r, pi_nxt;
  logic signed [DW:0]   pd_r, pd_nxt;
  logic [MW-1:0]        acc_hi_r, acc_hi_nxt, acc_lo_r, acc_lo_nxt, mcand_r, mcand_nxt;
  logic                 neg_r, neg_nxt;
  logic [FW-1:0]        res_drive_r, res_drive_nxt;
  logic                 res_frozen_r, res_frozen_nxt;
  logic [FW-1:0]        out_drive_r;
  logic                 out_frozen_r;

  // Handshake and sequencer outputs
  logic in_fire, out_load;

  // Shared add/subtract unit
  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_sum;

  // Error with saturation
  logic signed [EW-1:0]   err_wide;
  logic [EW-DW:0]         err_top;
  logic signed [DW-1:0]   err_sat;

  // Divide setup
  logic [DW:0]     div_mag;
  logic [DW+F:0]   div_num;
  logic [F:0]      div_hi;
  logic [DW-1:0]   div_lo;
  logic            div_zero, div_ovf;
  logic [FW-1:0]   div_t;
  logic [DW-1:0]   div_q;

  // Multiply setup and result
  logic signed [MW-1:0] op_a, op_b;
  logic [MW-1:0]        mag_a, mag_b;
  logic [2*MW-1:0]      prod;
  logic                 mul_ovf;
  logic [DW-1:0]        mul_mag;
  logic signed [DW-1:0] mul_res;

  // Integral, check and clamp
  logic signed [DW:0]   pi_wide;
  logic signed [DW-1:0] pi_sat;
  logic signed [SW-1:0] sum_chk, sum_out, ceil_ext, floor_ext, lim, drv;
  logic                 in_window;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_frozen_r;

  // Error = target - measurement, saturated to the datapath width
  assign err_wide = EW'(signed'(in_tdata[31:0])) - EW'(signed'(in_tdata[63:32]));
  assign err_top  = err_wide[EW-1:DW-1];
  assign err_sat  = ((&err_top) || !(|err_top)) ? err_wide[DW-1:0]
                  : (err_wide[EW-1] ? SAT_MIN : SAT_MAX);

  // Divide setup: magnitude of the error change, scaled numerator
  assign div_mag  = diff_r[DW] ? (DW+1)'(-diff_r) : diff_r;
  assign div_num  = {div_mag, {F{1'b0}}};
  assign div_hi   = div_num[DW+F:DW];
  assign div_lo   = div_num[DW-1:0];
  assign div_zero = (diff_r == '0);
  assign div_ovf  = (per_r == '0) || (FW'(div_hi) >= FW'(per_r));
  assign div_t    = {acc_hi_r[FW-2:0], acc_lo_r[DW-1]};
  assign div_q    = acc_lo_r[DW-1:0];

  // Multiply operand selection
  always_comb begin
    case (mul_sel_r)
      pidaw_pkg::MUL_P: begin
        op_a = MW'(kp_r);
        op_b = MW'(err_r);
      end
      pidaw_pkg::MUL_D: begin
        op_a = MW'(kd_r);
        op_b = MW'(dq_r);
      end
      pidaw_pkg::MUL_T: begin
        op_a = MW'(ki_r);
        op_b = MW'(err_r);
      end
      default: begin
        op_a = MW'(t_r);
        op_b = signed'(MW'(per_r));
      end
    endcase
  end

  assign mag_a = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
  assign mag_b = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);

  // Product shifted down by the fraction bits, saturated
  assign prod    = {acc_hi_r, acc_lo_r};
  assign mul_ovf = |prod[2*MW-1:F+DW-1];
  assign mul_mag = {1'b0, prod[F+DW-2:F]};
  assign mul_res = mul_ovf ? (neg_r ? SAT_MIN : SAT_MAX)
                 : (neg_r ? signed'(DW'(0) - mul_mag) : signed'(mul_mag));

  // Prospective integral, saturated
  assign pi_wide = (DW+1)'(integ_r) + (DW+1)'(inc_r);
  assign pi_sat  = (pi_wide[DW] == pi_wide[DW-1]) ? pi_wide[DW-1:0]
                 : (pi_wide[DW] ? SAT_MIN : SAT_MAX);

  // Window test on the prospective sum, clamp on the committed sum
  assign ceil_ext  = SW'(ceil_r);
  assign floor_ext = SW'(floor_r);
  assign sum_chk   = SW'(pd_r) + SW'(pi_r);
  assign in_window = (sum_chk <= ceil_ext) && (sum_chk >= floor_ext);
  assign sum_out   = SW'(pd_r) + SW'(integ_r);
  assign lim       = (sum_out < ceil_ext) ? sum_out : ceil_ext;
  assign drv       = (lim < floor_ext) ? floor_ext : lim;

  // Shared unit: subtract the period while dividing, add multiplicand otherwise
  always_comb begin
    if (state_r == pidaw_pkg::ST_DIV) begin
      alu_a   = AW'(div_t);
      alu_b   = AW'(per_r);
      alu_sub = 1'b1;
    end else begin
      alu_a   = {1'b0, acc_hi_r};
      alu_b   = acc_lo_r[0] ? {1'b0, mcand_r} : '0;
      alu_sub = 1'b0;
    end
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{AW{1'b0}}, alu_sub};

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidaw_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser[0] == pidaw_pkg::OP_CLEAR) ? pidaw_pkg::ST_DONE
                                                           : pidaw_pkg::ST_DIFF;
        end
      end
      pidaw_pkg::ST_DIFF:      state_nxt = pidaw_pkg::ST_DIV_SETUP;
      pidaw_pkg::ST_DIV_SETUP: begin
        state_nxt = (div_zero || div_ovf) ? pidaw_pkg::ST_MUL_SETUP : pidaw_pkg::ST_DIV;
      end
      pidaw_pkg::ST_DIV: begin
        if (cnt_r == CW'(1)) state_nxt = pidaw_pkg::ST_DIV_DONE;
      end
      pidaw_pkg::ST_DIV_DONE:  state_nxt = pidaw_pkg::ST_MUL_SETUP;
      pidaw_pkg::ST_MUL_SETUP: state_nxt = pidaw_pkg::ST_MUL;
      pidaw_pkg::ST_MUL: begin
        if (cnt_r == CW'(1)) state_nxt = pidaw_pkg::ST_MUL_DONE;
      end
      pidaw_pkg::ST_MUL_DONE: begin
        state_nxt = (mul_sel_r == pidaw_pkg::MUL_INC) ? pidaw_pkg::ST_SUMS
                                                     : pidaw_pkg::ST_MUL_SETUP;
      end
      pidaw_pkg::ST_SUMS:  state_nxt = pidaw_pkg::ST_CHECK;
      pidaw_pkg::ST_CHECK: state_nxt = pidaw_pkg::ST_CLAMP;
      pidaw_pkg::ST_CLAMP: state_nxt = pidaw_pkg::ST_DONE;
      pidaw_pkg::ST_DONE: begin
        if (out_load) state_nxt = pidaw_pkg::ST_IDLE;
      end
      default: state_nxt = pidaw_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = (state_r == pidaw_pkg::ST_IDLE);
    out_load  = (state_r == pidaw_pkg::ST_DONE) && (!out_valid_r || out_tready);
  end

  assign in_fire = in_tvalid && in_tready;

  // Datapath next values
  always_comb begin
    integ_nxt      = integ_r;
    last_err_nxt   = last_err_r;
    err_nxt        = err_r;
    diff_nxt       = diff_r;
    dq_nxt         = dq_r;
    p_nxt          = p_r;
    dterm_nxt      = dterm_r;
    t_nxt          = t_r;
    inc_nxt        = inc_r;
    pi_nxt         = pi_r;
    pd_nxt         = pd_r;
    acc_hi_nxt     = acc_hi_r;
    acc_lo_nxt     = acc_lo_r;
    mcand_nxt      = mcand_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    mul_sel_nxt    = mul_sel_r;
    res_drive_nxt  = res_drive_r;
    res_frozen_nxt = res_frozen_r;
    case (state_r)
      pidaw_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == pidaw_pkg::OP_CLEAR) begin
            integ_nxt      = '0;
            last_err_nxt   = '0;
            res_drive_nxt  = '0;
            res_frozen_nxt = 1'b0;
          end else begin
            err_nxt = err_sat;
          end
        end
      end
      pidaw_pkg::ST_DIFF: begin
        diff_nxt    = (DW+1)'(err_r) - (DW+1)'(last_err_r);
        mul_sel_nxt = pidaw_pkg::MUL_P;
      end
      pidaw_pkg::ST_DIV_SETUP: begin
        neg_nxt = diff_r[DW];
        if (div_zero) begin
          dq_nxt = '0;
        end else if (div_ovf) begin
          dq_nxt = diff_r[DW] ? SAT_MIN : SAT_MAX;
        end else begin
          // upper numerator bits seed the remainder, lower bits shift in
          acc_hi_nxt            = MW'(div_hi);
          acc_lo_nxt[DW-1:0]    = div_lo;
          cnt_nxt               = CW'(DW);
        end
      end
      pidaw_pkg::ST_DIV: begin
        // restoring step: keep the difference when the period fits
        acc_hi_nxt         = alu_sum[AW] ? MW'(alu_sum[FW-1:0]) : MW'(div_t);
        acc_lo_nxt[DW-1:0] = {acc_lo_r[DW-2:0], alu_sum[AW]};
        cnt_nxt            = cnt_r - CW'(1);
      end
      pidaw_pkg::ST_DIV_DONE: begin
        if (div_q[DW-1]) begin
          dq_nxt = neg_r ? SAT_MIN : SAT_MAX;
        end else begin
          dq_nxt = neg_r ? signed'(DW'(0) - div_q) : signed'(div_q);
        end
      end
      pidaw_pkg::ST_MUL_SETUP: begin
        neg_nxt    = op_a[MW-1] ^ op_b[MW-1];
        acc_hi_nxt = '0;
        acc_lo_nxt = mag_b;
        mcand_nxt  = mag_a;
        cnt_nxt    = CW'(MW);
      end
      pidaw_pkg::ST_MUL: begin
        // add on the low multiplier bit, then shift the pair right
        acc_hi_nxt = alu_sum[MW:1];
        acc_lo_nxt = {alu_sum[0], acc_lo_r[MW-1:1]};
        cnt_nxt    = cnt_r - CW'(1);
      end
      pidaw_pkg::ST_MUL_DONE: begin
        case (mul_sel_r)
          pidaw_pkg::MUL_P: p_nxt     = mul_res;
          pidaw_pkg::MUL_D: dterm_nxt = mul_res;
          pidaw_pkg::MUL_T: t_nxt     = mul_res;
          default:          inc_nxt   = mul_res;
        endcase
        mul_sel_nxt = pidaw_pkg::mul_sel_t'(mul_sel_r + 2'd1);
      end
      pidaw_pkg::ST_SUMS: begin
        pi_nxt = pi_sat;
        pd_nxt = (DW+1)'(p_r) + (DW+1)'(dterm_r);
      end
      pidaw_pkg::ST_CHECK: begin
        // commit the integral only when the prospective drive stays in range
        if (in_window) integ_nxt = pi_r;
        res_frozen_nxt = !in_window;
      end
      pidaw_pkg::ST_CLAMP: begin
        res_drive_nxt = drv[FW-1:0];
        last_err_nxt  = err_r;
      end
      default: begin
      end
    endcase
  end

  // Control and controller state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidaw_pkg::ST_IDLE;
      mul_sel_r   <= pidaw_pkg::MUL_P;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
      kp_r        <= pidaw_pkg::PROP_GAIN_RST;
      ki_r        <= pidaw_pkg::INT_GAIN_RST;
      kd_r        <= pidaw_pkg::DERIV_GAIN_RST;
      per_r       <= pidaw_pkg::SAMPLE_PERIOD_RST;
      floor_r     <= pidaw_pkg::DRIVE_FLOOR_RST;
      ceil_r      <= pidaw_pkg::DRIVE_CEILING_RST;
    end else begin
      state_r    <= state_nxt;
      mul_sel_r  <= mul_sel_nxt;
      cnt_r      <= cnt_nxt;
      integ_r    <= integ_nxt;
      last_err_r <= last_err_nxt;
      // hold the result until the receiver takes it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pidaw_pkg::CFG_PROP_GAIN:     kp_r    <= signed'(cfg_data);
          pidaw_pkg::CFG_INT_GAIN:      ki_r    <= signed'(cfg_data);
          pidaw_pkg::CFG_DERIV_GAIN:    kd_r    <= signed'(cfg_data);
          pidaw_pkg::CFG_SAMPLE_PERIOD: per_r   <= cfg_data[PW-1:0];
          pidaw_pkg::CFG_DRIVE_FLOOR:   floor_r <= signed'(cfg_data);
          pidaw_pkg::CFG_DRIVE_CEILING: ceil_r  <= signed'(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    err_r        <= err_nxt;
    diff_r       <= diff_nxt;
    dq_r         <= dq_nxt;
    p_r          <= p_nxt;
    dterm_r      <= dterm_nxt;
    t_r          <= t_nxt;
    inc_r        <= inc_nxt;
    pi_r         <= pi_nxt;
    pd_r         <= pd_nxt;
    acc_hi_r     <= acc_hi_nxt;
    acc_lo_r     <= acc_lo_nxt;
    mcand_r      <= mcand_nxt;
    neg_r        <= neg_nxt;
    res_drive_r  <= res_drive_nxt;
    res_frozen_r <= res_frozen_nxt;
    if (out_load) begin
      out_drive_r  <= res_drive_r;
      out_frozen_r <= res_frozen_r;
    end
  end

endmodule
